/* rtl/core/ialu_pkg.sv */
// Package holding the operation codes, widths and helper functions of the 32-bit integer ALU.
package ialu_pkg;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OP_W     = 5;
    localparam int unsigned SH_W     = 5;
    localparam int unsigned DIV_STEP = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INC  = 5'd0,  OP_DEC  = 5'd1,  OP_ADD  = 5'd2,  OP_SUB  = 5'd3,
        OP_MUL  = 5'd4,  OP_DIV  = 5'd5,  OP_MOD  = 5'd6,  OP_MAX  = 5'd7,
        OP_MIN  = 5'd8,  OP_ABS  = 5'd9,  OP_SIGN = 5'd10, OP_AND  = 5'd11,
        OP_OR   = 5'd12, OP_NOT  = 5'd13, OP_NAND = 5'd14, OP_XOR  = 5'd15,
        OP_SLR  = 5'd16, OP_SAR  = 5'd17, OP_SLL  = 5'd18, OP_ROR  = 5'd19,
        OP_ROL  = 5'd20, OP_SET  = 5'd21, OP_CLR  = 5'd22, OP_TGL  = 5'd23,
        OP_TEST = 5'd24, OP_UMUL = 5'd25, OP_UDIV = 5'd26, OP_UMOD = 5'd27,
        OP_UMAX = 5'd28, OP_UMIN = 5'd29, OP_CMP  = 5'd30, OP_UCMP = 5'd31
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_result;
        logic              divide_fault;
        logic              is_div;
        logic              is_rem;
        logic              neg_q;
        logic              neg_r;
    } t_ctl;

    function automatic logic [DATA_W-1:0] cmp3(input logic lt, input logic eq);
        if (eq) begin
            return '0;
        end else if (lt) begin
            return '1;
        end
        return {{(DATA_W-1){1'b0}}, 1'b1};
    endfunction
endpackage

/* rtl/core/ialu_div.sv */
// Pipelined unsigned divider: DATA_W/STEP_BITS stages, each resolving STEP_BITS quotient bits.
module ialu_div
    import ialu_pkg::*;
#(
    parameter int unsigned STEP_BITS = DIV_STEP
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    input  t_ctl              i_ctl,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem,
    output t_ctl              o_ctl
);
    localparam int unsigned NSTG = DATA_W / STEP_BITS;

    logic [DATA_W-1:0] r_q   [1:NSTG];
    logic [DATA_W-1:0] r_rm  [1:NSTG];
    logic [DATA_W-1:0] r_d   [1:NSTG];
    t_ctl              r_c   [1:NSTG];
    logic [NSTG:1]     r_v;

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic [DATA_W-1:0] c_q;
        logic [DATA_W-1:0] c_rm;
        logic [DATA_W-1:0] c_d;
        t_ctl              c_c;
        logic              c_v;
        logic [DATA_W-1:0] n_q;
        logic [DATA_W-1:0] n_rm;
        if (g == 0) begin : g_first
            assign c_q  = i_dividend;
            assign c_rm = '0;
            assign c_d  = i_divisor;
            assign c_c  = i_ctl;
            assign c_v  = i_valid;
        end else begin : g_next
            assign c_q  = r_q[g];
            assign c_rm = r_rm[g];
            assign c_d  = r_d[g];
            assign c_c  = r_c[g];
            assign c_v  = r_v[g];
        end
        always_comb begin
            logic [DATA_W:0] t;
            n_q  = c_q;
            n_rm = c_rm;
            for (int k = 0; k < STEP_BITS; k++) begin
                t = {n_rm, n_q[DATA_W-1]};
                n_q = {n_q[DATA_W-2:0], 1'b0};
                if (t >= {1'b0, c_d}) begin
                    t = t - {1'b0, c_d};
                    n_q[0] = 1'b1;
                end
                n_rm = t[DATA_W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= c_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1]  <= n_q;
                r_rm[g+1] <= n_rm;
                r_d[g+1]  <= c_d;
                r_c[g+1]  <= c_c;
            end
        end
    end

    assign o_valid = r_v[NSTG];
    assign o_quot  = r_q[NSTG];
    assign o_rem   = r_rm[NSTG];
    assign o_ctl   = r_c[NSTG];

    a_div_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_v[1] == $past(i_valid)) else $error("divider valid lost");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v)) else $error("divider moved while stalled");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ctl.is_div && o_ctl.write_result && !o_ctl.divide_fault
        |-> o_rem < r_d[NSTG]) else $error("remainder not below divisor");
endmodule

/* rtl/core/integer_alu_32_unit.sv */
// Top level of the 32-bit integer ALU: decode stage, pipelined divider and output register.
// An input transaction passes the decode register, the divider stages and the output register in turn.
// Throughput: one transaction per cycle unless stalled; the whole pipeline advances together.
// The pipeline stalls only while the output register holds an untaken result.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module integer_alu_32_unit
    import ialu_pkg::*;
#(
    parameter int unsigned STEP_BITS = DIV_STEP
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // action[4:0], operand_a[36:5], operand_b[68:37], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result[31:0], write_result[32], divide_fault[33], zero
);
    logic              en;
    t_op               op;
    logic [DATA_W-1:0] a, b;
    t_ctl              n_ctl, d_ctl;
    logic              d_valid;
    logic [DATA_W-1:0] d_quot, d_rem;
    logic [DATA_W-1:0] r_dvd, r_dvs;
    t_ctl              r_ctl;
    logic              r_valid, r_ovalid;
    logic [DATA_W-1:0] r_ores;
    logic              r_owr, r_oflt;
    logic [DATA_W-1:0] n_res;

    assign en            = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;
    assign op = t_op'(s_axis_tdata[4:0]);
    assign a  = s_axis_tdata[36:5];
    assign b  = s_axis_tdata[68:37];

    always_comb begin
        logic lts, ltu, eq, na, nb, bad_b;
        logic [SH_W-1:0] s;
        lts   = $signed(a) < $signed(b);
        ltu   = a < b;
        eq    = a == b;
        na    = a[DATA_W-1];
        nb    = b[DATA_W-1];
        s     = b[SH_W-1:0];
        bad_b = |b[DATA_W-1:SH_W];
        n_ctl = '0;
        n_ctl.write_result = 1'b1;
        case (op)
            OP_INC:  n_ctl.result = a + 1'b1;
            OP_DEC:  n_ctl.result = a - 1'b1;
            OP_ADD:  n_ctl.result = a + b;
            OP_SUB:  n_ctl.result = a - b;
            OP_MUL, OP_UMUL: n_ctl.result = a * b;
            OP_DIV, OP_MOD, OP_UDIV, OP_UMOD: begin
                n_ctl.is_div = 1'b1;
                n_ctl.is_rem = (op == OP_MOD) || (op == OP_UMOD);
                if (b == '0) begin
                    n_ctl.write_result = 1'b0;
                    n_ctl.divide_fault = 1'b1;
                end
                if (op == OP_DIV || op == OP_MOD) begin
                    n_ctl.neg_q = na ^ nb;
                    n_ctl.neg_r = na;
                end
            end
            OP_MAX:  n_ctl.result = lts ? b : a;
            OP_MIN:  n_ctl.result = lts ? a : b;
            OP_ABS:  n_ctl.result = na ? -a : a;
            OP_SIGN: n_ctl.result = cmp3(na, a == '0);
            OP_AND:  n_ctl.result = a & b;
            OP_OR:   n_ctl.result = a | b;
            OP_NOT:  n_ctl.result = ~a;
            OP_NAND: n_ctl.result = ~(a & b);
            OP_XOR:  n_ctl.result = a ^ b;
            OP_SLR:  n_ctl.result = bad_b ? '0 : a >> s;
            OP_SAR:  n_ctl.result = bad_b ? {DATA_W{na}} : DATA_W'($signed(a) >>> s);
            OP_SLL:  n_ctl.result = bad_b ? '0 : a << s;
            OP_ROR:  n_ctl.result = (a >> s) | (a << (SH_W'(0) - s));
            OP_ROL:  n_ctl.result = (a << s) | (a >> (SH_W'(0) - s));
            OP_SET, OP_CLR, OP_TGL, OP_TEST: begin
                if (bad_b) begin
                    n_ctl.write_result = 1'b0;
                end else if (op == OP_SET) begin
                    n_ctl.result = a | (DATA_W'(1) << s);
                end else if (op == OP_CLR) begin
                    n_ctl.result = a & ~(DATA_W'(1) << s);
                end else if (op == OP_TGL) begin
                    n_ctl.result = a ^ (DATA_W'(1) << s);
                end else begin
                    n_ctl.result = DATA_W'(a[s]);
                end
            end
            OP_UMAX: n_ctl.result = ltu ? b : a;
            OP_UMIN: n_ctl.result = ltu ? a : b;
            OP_CMP:  n_ctl.result = cmp3(lts, eq);
            OP_UCMP: n_ctl.result = cmp3(ltu, eq);
            default: n_ctl.result = '0;
        endcase
    end

    // The first stage registers the decoded item, the divider operands and the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl <= n_ctl;
            r_dvd <= (n_ctl.neg_r) ? -a : a;
            r_dvs <= (n_ctl.is_div && (op == OP_DIV || op == OP_MOD) && b[DATA_W-1]) ? -b : b;
        end
    end

    ialu_div #(.STEP_BITS(STEP_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_valid),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .i_ctl      (r_ctl),
        .o_valid    (d_valid),
        .o_quot     (d_quot),
        .o_rem      (d_rem),
        .o_ctl      (d_ctl)
    );

    always_comb begin
        n_res = d_ctl.result;
        if (d_ctl.is_div) begin
            if (d_ctl.divide_fault) begin
                n_res = '0;
            end else if (d_ctl.is_rem) begin
                n_res = d_ctl.neg_r ? -d_rem : d_rem;
            end else begin
                n_res = d_ctl.neg_q ? -d_quot : d_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ores <= n_res;
            r_owr  <= d_ctl.write_result;
            r_oflt <= d_ctl.divide_fault;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_oflt, r_owr, r_ores};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_fault_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[32] && m_axis_tdata[31:0] == '0)
        else $error("fault with write");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("input blocked while output empty");
endmodule

/* tb/integer_alu_32_unit_tb.sv */
// Self-checking testbench of the 32-bit integer ALU: directed and random operations against a predictor.
module integer_alu_32_unit_tb;
    import ialu_pkg::*;

    typedef struct packed {
        logic [31:0] result;
        logic        write_result;
        logic        divide_fault;
    } t_alu_res;

    class alu_scoreboard;
        t_alu_res pending[$];
        int       mismatches;
        int       checked;

        function automatic t_alu_res predict(t_op op, logic [31:0] a, logic [31:0] b);
            t_alu_res    r;
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] m;
            logic [4:0]  sh;
            logic        lt_s;
            sh = b[4:0];
            r.result = '0;
            r.write_result = 1'b1;
            r.divide_fault = 1'b0;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            lt_s = $signed(a) < $signed(b);
            case (op)
                OP_INC:  r.result = a + 32'd1;
                OP_DEC:  r.result = a - 32'd1;
                OP_ADD:  r.result = a + b;
                OP_SUB:  r.result = a - b;
                OP_MUL, OP_UMUL: r.result = a * b;
                OP_DIV, OP_MOD: begin
                    if (b == 0) begin
                        r.write_result = 1'b0;
                        r.divide_fault = 1'b1;
                    end else if (op == OP_DIV) begin
                        m = ma / mb;
                        r.result = (a[31] != b[31]) ? -m : m;
                    end else begin
                        m = ma % mb;
                        r.result = a[31] ? -m : m;
                    end
                end
                OP_MAX:  r.result = lt_s ? b : a;
                OP_MIN:  r.result = lt_s ? a : b;
                OP_ABS:  r.result = ma;
                OP_SIGN: r.result = (a == 0) ? 32'd0 : (a[31] ? '1 : 32'd1);
                OP_AND:  r.result = a & b;
                OP_OR:   r.result = a | b;
                OP_NOT:  r.result = ~a;
                OP_NAND: r.result = ~(a & b);
                OP_XOR:  r.result = a ^ b;
                OP_SLR:  r.result = (b >= 32) ? 32'd0 : a >> sh;
                OP_SAR:  r.result = (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> sh);
                OP_SLL:  r.result = (b >= 32) ? 32'd0 : a << sh;
                OP_ROR:  r.result = 32'({a, a} >> sh);
                OP_ROL:  r.result = 32'(({a, a} << sh) >> 32);
                OP_SET, OP_CLR, OP_TGL, OP_TEST: begin
                    if (b > 31) begin
                        r.write_result = 1'b0;
                    end else begin
                        case (op)
                            OP_SET:  r.result = a | (32'd1 << sh);
                            OP_CLR:  r.result = a & ~(32'd1 << sh);
                            OP_TGL:  r.result = a ^ (32'd1 << sh);
                            default: r.result = {31'd0, a[sh]};
                        endcase
                    end
                end
                OP_UDIV, OP_UMOD: begin
                    if (b == 0) begin
                        r.write_result = 1'b0;
                        r.divide_fault = 1'b1;
                    end else begin
                        r.result = (op == OP_UDIV) ? a / b : a % b;
                    end
                end
                OP_UMAX: r.result = (a < b) ? b : a;
                OP_UMIN: r.result = (a < b) ? a : b;
                OP_CMP:  r.result = (a == b) ? 32'd0 : (lt_s ? '1 : 32'd1);
                default: r.result = (a == b) ? 32'd0 : ((a < b) ? '1 : 32'd1);
            endcase
            return r;
        endfunction

        function void note_operation(logic [71:0] data);
            pending.push_back(predict(t_op'(data[4:0]), data[36:5], data[68:37]));
        endfunction

        task check_result(logic [39:0] data);
            t_alu_res want;
            if (pending.size() == 0) begin
                report_error($sformatf("unexpected result %h", data));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (data[31:0] !== want.result)
                report_error($sformatf("result %h, expected %h", data[31:0], want.result));
            if (data[32] !== want.write_result)
                report_error($sformatf("write_result %b, expected %b", data[32], want.write_result));
            if (data[33] !== want.divide_fault)
                report_error($sformatf("divide_fault %b, expected %b", data[33], want.divide_fault));
        endtask

        task report_error(string msg);
            mismatches++;
            if (mismatches <= 50) $display("mismatch: %s", msg);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;  // action, operand_a, operand_b, zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;  // result, write_result, divide_fault, zero

    alu_scoreboard board;
    int            cycles;
    int            sent;
    bit            calm;
    bit            hold_off;
    bit            timed_out;

    integer_alu_32_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000 && !timed_out) begin
            timed_out = 1'b1;
            $display("integer_alu_32_unit regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 33);
    end

    task automatic send_operation(t_op op, logic [31:0] a, logic [31:0] b);
        while (!calm && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {3'd0, b, a, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_operation(s_axis_tdata);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(40);
            5: return -$urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        int          wait_cycles;
        board = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cycles = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_operation(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_operation(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_operation(OP_DIV, 32'd7, 32'd0);
        send_operation(OP_MOD, 32'hFFFF_FFF9, 32'd0);
        send_operation(OP_UDIV, 32'hFFFF_FFFF, 32'd0);
        send_operation(OP_UMOD, 32'd5, 32'd0);
        send_operation(OP_DIV, 32'hFFFF_FFF9, 32'd2);
        send_operation(OP_MOD, 32'hFFFF_FFF9, 32'd2);
        send_operation(OP_ABS, 32'h8000_0000, 32'd0);
        send_operation(OP_SLR, 32'hFFFF_FFFF, 32'd32);
        send_operation(OP_SLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operation(OP_SAR, 32'h8000_0001, 32'd40);
        send_operation(OP_SAR, 32'h7FFF_FFFF, 32'd32);
        send_operation(OP_ROR, 32'h1234_5678, 32'd36);
        send_operation(OP_ROL, 32'h8765_4321, 32'hFFFF_FFFF);
        send_operation(OP_SET, 32'd0, 32'd31);
        send_operation(OP_TEST, 32'hFFFF_FFFF, 32'd32);
        send_operation(OP_TGL, 32'd0, 32'h8000_0000);
        send_operation(OP_SIGN, 32'd0, 32'd0);
        send_operation(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF);
        send_operation(OP_UCMP, 32'h8000_0000, 32'h7FFF_FFFF);
        send_operation(OP_INC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // The receiver stalls while the sender keeps the pipeline full.
        fork
            begin
                hold_off = 1'b1;
                wait_cycles = 0;
                while (wait_cycles < 60) begin
                    @(posedge i_clk);
                    wait_cycles++;
                end
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++)
                    send_operation(t_op'($urandom_range(31)), $urandom, $urandom);
            end
        join

        for (int i = 0; i < 1800; i++) begin
            calm = (i >= 600 && i < 800);
            a = pick_word();
            b = pick_word();
            send_operation(t_op'($urandom_range(31)), a, b);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d operations over all 32 codes, %0d results checked.",
                 sent, board.checked);
        $display("Included divide faults, overflow repairs, long shifts and output stalls.");
        if (board.mismatches == 0) begin
            $display("integer_alu_32_unit regression: pass");
        end else begin
            $display("integer_alu_32_unit regression: fail");
        end
        $finish;
    end
endmodule
